>>> rtl/urrlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urrlr_pkg
// Shared sizes, codes and controller/datapath command and status types of
// the receive ring line reader.
// ----------------------------------------------------------------------------
package urrlr_pkg;

  // Storage and field sizes
  localparam int BUFFER_DEPTH = 256;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int LINE_LIMIT   = 64;
  localparam int DATA_W       = 8;
  localparam int CNT_W        = 6;
  localparam int PEND_W       = 8;
  localparam int SIZE_CFG_W   = 9;
  localparam int LEN_CFG_W    = 7;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 2;

  // Configuration reset values
  localparam int SIZE_RESET  = 256;
  localparam int LEN_RESET   = 64;
  localparam int DELIM_RESET = 10;

  // Request codes
  typedef enum logic [1:0] {
    REQ_RECEIVE   = 2'd0,
    REQ_READ_BYTE = 2'd1,
    REQ_READ_LINE = 2'd2,
    REQ_QUERY     = 2'd3
  } req_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_SIZE = 2'd0,
    REG_LINE_MAX    = 2'd1,
    REG_LINE_DELIM  = 2'd2
  } cfg_reg_t;

  // Memory read address source
  typedef enum logic [1:0] {
    ADDR_READ = 2'd0,
    ADDR_SCAN = 2'd1,
    ADDR_EMIT = 2'd2
  } addr_sel_t;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    RES_PLAIN      = 2'd0,
    RES_BYTE       = 2'd1,
    RES_LINE_EMPTY = 2'd2,
    RES_LINE_CHAR  = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic      wr_byte;
    logic      mem_rd;
    addr_sel_t addr_sel;
    logic      pop;
    logic      scan_start;
    logic      scan_step;
    logic      line_commit;
    logic      emit_step;
    logic      out_load;
    res_kind_t res_kind;
  } urrlr_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_end;
    logic match;
    logic kept_zero;
    logic emit_last;
    logic out_free;
  } urrlr_sts_t;

endpackage

>>> rtl/urrlr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urrlr_in_if / urrlr_out_if
// Valid/ready channels: request transactions in, result transactions out.
// ----------------------------------------------------------------------------
interface urrlr_in_if
  import urrlr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [DATA_W-1:0] rx_data;

  modport source (output valid, output req_type, output rx_data, input ready);
  modport sink   (input valid, input req_type, input rx_data, output ready);
endinterface

interface urrlr_out_if
  import urrlr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              data_valid;
  logic              line_found;
  logic [CNT_W-1:0]  char_count;
  logic [PEND_W-1:0] pending_count;
  logic              last;

  modport source (output valid, output data_byte, output data_valid, output line_found,
                  output char_count, output pending_count, output last, input ready);
  modport sink   (input valid, input data_byte, input data_valid, input line_found,
                  input char_count, input pending_count, input last, output ready);
endinterface

>>> rtl/urrlr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urrlr_dp
// Datapath: configuration registers, ring indices, byte memory, line scan
// pointers and counters, and the output register.
// ----------------------------------------------------------------------------
module urrlr_dp
  import urrlr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [DATA_W-1:0]    rx_data,
  input  urrlr_cmd_t           cmd,
  output urrlr_sts_t           sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [DATA_W-1:0]    out_data_byte,
  output logic                 out_data_valid,
  output logic                 out_line_found,
  output logic [CNT_W-1:0]     out_char_count,
  output logic [PEND_W-1:0]    out_pending_count,
  output logic                 out_last
);

  localparam int SZ_W  = IDX_W + 1;
  localparam int CMP_W = (SZ_W > SIZE_CFG_W) ? SZ_W : SIZE_CFG_W;

  logic [SIZE_CFG_W-1:0] buffer_size_r;
  logic [LEN_CFG_W-1:0]  line_max_r;
  logic [DATA_W-1:0]     line_delim_r;

  logic [IDX_W-1:0]  wr_idx_r, rd_idx_r, scan_ptr_r, emit_ptr_r;
  logic [CNT_W-1:0]  kept_cnt_r, emit_idx_r;
  logic [DATA_W-1:0] rdata_r;
  logic [DATA_W-1:0] mem [BUFFER_DEPTH];

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_dvalid_r, out_found_r, out_last_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [PEND_W-1:0] out_pend_r;

  logic [CMP_W-1:0]     size_ext;
  logic [SZ_W-1:0]      size_use;
  logic [LEN_CFG_W-1:0] len_lim;
  logic [CNT_W-1:0]     cap;
  logic [SZ_W-1:0]      pend_raw;
  logic [PEND_W-1:0]    pend_now;
  logic [IDX_W-1:0]     rd_addr;
  logic                 out_free;

  // Step an index on, wrapping at the size in use
  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                           input logic [SZ_W-1:0]  size);
    logic [SZ_W-1:0] n;
    n = {1'b0, idx} + 1'b1;
    return (n >= size) ? '0 : n[IDX_W-1:0];
  endfunction

  // Clamp the size register into the range the memory supports
  always_comb begin
    size_ext = CMP_W'(buffer_size_r);
    if (size_ext < CMP_W'(2)) begin
      size_use = SZ_W'(2);
    end else if (size_ext > CMP_W'(BUFFER_DEPTH)) begin
      size_use = SZ_W'(BUFFER_DEPTH);
    end else begin
      size_use = SZ_W'(size_ext);
    end
  end

  // Line capacity: clamp to the limit, keep one fewer
  always_comb begin
    len_lim = (line_max_r > LEN_CFG_W'(LINE_LIMIT)) ? LEN_CFG_W'(LINE_LIMIT) : line_max_r;
    cap     = (len_lim == '0) ? '0 : CNT_W'(len_lim - 1'b1);
  end

  // Pending count from the current indices, saturated
  always_comb begin
    if (wr_idx_r >= rd_idx_r) begin
      pend_raw = SZ_W'(wr_idx_r - rd_idx_r);
    end else begin
      pend_raw = size_use - SZ_W'(rd_idx_r) + SZ_W'(wr_idx_r);
    end
    pend_now = (32'(pend_raw) > 255) ? {PEND_W{1'b1}} : PEND_W'(pend_raw);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= SIZE_CFG_W'(SIZE_RESET);
      line_max_r    <= LEN_CFG_W'(LEN_RESET);
      line_delim_r  <= DATA_W'(DELIM_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BUFFER_SIZE: buffer_size_r <= cfg_wdata[SIZE_CFG_W-1:0];
        REG_LINE_MAX:    line_max_r    <= cfg_wdata[LEN_CFG_W-1:0];
        REG_LINE_DELIM:  line_delim_r  <= cfg_wdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring indices; a size write restarts both
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else if (cfg_we && (cfg_idx == REG_BUFFER_SIZE)) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.wr_byte) begin
        wr_idx_r <= adv(wr_idx_r, size_use);
      end
      if (cmd.pop) begin
        rd_idx_r <= adv(rd_idx_r, size_use);
      end else if (cmd.line_commit) begin
        rd_idx_r <= adv(scan_ptr_r, size_use);
      end
    end
  end

  // Line scan and emit pointers and counters
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_ptr_r <= rd_idx_r;
      emit_ptr_r <= rd_idx_r;
      kept_cnt_r <= '0;
      emit_idx_r <= '0;
    end else begin
      if (cmd.scan_step) begin
        scan_ptr_r <= adv(scan_ptr_r, size_use);
        if (kept_cnt_r < cap) begin
          kept_cnt_r <= kept_cnt_r + 1'b1;
        end
      end
      if (cmd.emit_step) begin
        emit_ptr_r <= adv(emit_ptr_r, size_use);
        emit_idx_r <= emit_idx_r + 1'b1;
      end
    end
  end

  // Byte memory: one write port, one registered read port
  always_comb begin
    case (cmd.addr_sel)
      ADDR_READ: rd_addr = rd_idx_r;
      ADDR_SCAN: rd_addr = scan_ptr_r;
      ADDR_EMIT: rd_addr = emit_ptr_r;
      default:   rd_addr = rd_idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      mem[wr_idx_r] <= rx_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Output register valid flag
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, shaped by result kind
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pend_r <= pend_now;
      case (cmd.res_kind)
        RES_PLAIN: begin
          out_data_r   <= '0;
          out_dvalid_r <= 1'b0;
          out_found_r  <= 1'b0;
          out_count_r  <= '0;
          out_last_r   <= 1'b1;
        end
        RES_BYTE: begin
          out_data_r   <= rdata_r;
          out_dvalid_r <= 1'b1;
          out_found_r  <= 1'b0;
          out_count_r  <= '0;
          out_last_r   <= 1'b1;
        end
        RES_LINE_EMPTY: begin
          out_data_r   <= '0;
          out_dvalid_r <= 1'b0;
          out_found_r  <= 1'b1;
          out_count_r  <= '0;
          out_last_r   <= 1'b1;
        end
        RES_LINE_CHAR: begin
          out_data_r   <= rdata_r;
          out_dvalid_r <= 1'b1;
          out_found_r  <= 1'b1;
          out_count_r  <= kept_cnt_r;
          out_last_r   <= sts.emit_last;
        end
        default: begin
          out_data_r   <= '0;
          out_dvalid_r <= 1'b0;
          out_found_r  <= 1'b0;
          out_count_r  <= '0;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    sts.empty     = (rd_idx_r == wr_idx_r);
    sts.scan_end  = (scan_ptr_r == wr_idx_r);
    sts.match     = (rdata_r == line_delim_r);
    sts.kept_zero = (kept_cnt_r == '0);
    sts.emit_last = (emit_idx_r == (kept_cnt_r - 1'b1));
    sts.out_free  = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_data_byte     = out_data_r;
  assign out_data_valid    = out_dvalid_r;
  assign out_line_found    = out_found_r;
  assign out_char_count    = out_count_r;
  assign out_pending_count = out_pend_r;
  assign out_last          = out_last_r;

endmodule

>>> rtl/urrlr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urrlr_ctrl
// Controller: takes one request, sequences memory reads, the delimiter scan
// and the line emission, and loads each result into the output register.
// ----------------------------------------------------------------------------
module urrlr_ctrl
  import urrlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_ready,
  input  urrlr_sts_t sts,
  output urrlr_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_RESP      = 9'b000000010,
    S_BYTE_DATA = 9'b000000100,
    S_BYTE_OUT  = 9'b000001000,
    S_SCAN_ADDR = 9'b000010000,
    S_SCAN_CMP  = 9'b000100000,
    S_LINE_CHK  = 9'b001000000,
    S_EMIT_ADDR = 9'b010000000,
    S_EMIT_DATA = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_RECEIVE: begin
              cmd.wr_byte = 1'b1;
              state_nxt   = S_RESP;
            end
            REQ_READ_BYTE: begin
              if (sts.empty) begin
                state_nxt = S_RESP;
              end else begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_READ;
                state_nxt    = S_BYTE_DATA;
              end
            end
            REQ_READ_LINE: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN_ADDR;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.res_kind = RES_PLAIN;
          state_nxt    = S_IDLE;
        end
      end
      S_BYTE_DATA: begin
        cmd.pop   = 1'b1;
        state_nxt = S_BYTE_OUT;
      end
      S_BYTE_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.res_kind = RES_BYTE;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN_ADDR: begin
        // No delimiter before the write index: nothing consumed
        if (sts.scan_end) begin
          state_nxt = S_RESP;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = ADDR_SCAN;
          state_nxt    = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          cmd.line_commit = 1'b1;
          state_nxt       = S_LINE_CHK;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SCAN_ADDR;
        end
      end
      S_LINE_CHK: begin
        if (!sts.kept_zero) begin
          state_nxt = S_EMIT_ADDR;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.res_kind = RES_LINE_EMPTY;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT_ADDR: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_EMIT;
        state_nxt    = S_EMIT_DATA;
      end
      S_EMIT_DATA: begin
        // Hold the read byte until the output register frees
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.res_kind  = RES_LINE_CHAR;
          cmd.emit_step = 1'b1;
          state_nxt     = sts.emit_last ? S_IDLE : S_EMIT_ADDR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/uart_rx_ring_line_reader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_ring_line_reader_unit
// Circular receive buffer with byte pop, line read and pending query.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake         | Carries
//  in_ch    | in        | valid/ready       | req_type, rx_data
//  out_ch   | out       | valid/ready       | data_byte .. last, one per result
//  cfg_*    | in        | write enable only | buffer_size, line_max_len, delimiter
//
//  Receive and query load one plain result; read byte reads the memory, pops
//  and loads the byte (a plain result when the ring is empty); a line read
//  scans each byte, the delimiter included, through the single registered
//  read port of the byte memory, then reads and emits each kept character,
//  or loads a plain result when no delimiter is waiting.
//  Reset is synchronous and active low; it clears ring indices, configuration and
//  the controller, and leaves the memory contents undefined.
//  A stalled result holds the output register and adds its stall cycles; a
//  new request is taken once the previous one has loaded its last result.
// ----------------------------------------------------------------------------
module uart_rx_ring_line_reader_unit
  import urrlr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  urrlr_in_if.sink             in_ch,
  urrlr_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  urrlr_cmd_t cmd;
  urrlr_sts_t sts;

  // Sequence requests
  urrlr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Store bytes and build results
  urrlr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .rx_data           (in_ch.rx_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_data_byte     (out_ch.data_byte),
    .out_data_valid    (out_ch.data_valid),
    .out_line_found    (out_ch.line_found),
    .out_char_count    (out_ch.char_count),
    .out_pending_count (out_ch.pending_count),
    .out_last          (out_ch.last)
  );

endmodule
